// ===== hdl/hdcs_pkg.sv =====
// hdcs_pkg: shared types and constants for the hard disk collision step core.
// Used by hard_disk_collision_step_core and its testbench.
// No dependencies.
package hdcs_pkg;

	localparam int unsigned MAX_DISKS_DEF = 64;

	// request / response kinds
	typedef enum logic [1:0] {
		REQ_LOAD = 2'd0,
		REQ_STEP = 2'd1,
		REQ_READ = 2'd2,
		REQ_NONE = 2'd3
	} req_kind_t;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 24;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_W   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_H   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DT      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 3'd4;

	// reset values
	localparam logic [13:0] BOX_W_RST  = 14'd500;
	localparam logic [13:0] BOX_H_RST  = 14'd650;
	localparam logic [23:0] RADIUS_RST = 24'd458752;
	localparam logic [23:0] DT_RST     = 24'd1677;
	localparam logic [6:0]  ACTIVE_RST = 7'd64;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_WAIT,
		ST_MV_RD,
		ST_MV_MUL,
		ST_MV_WR,
		ST_PI_RD,
		ST_PI_LAT,
		ST_PAIR,
		ST_WALL,
		ST_RESP
	} state_t;

endpackage

// ===== hdl/hdcs_req_if.sv =====
// hdcs_req_if: request channel (valid/ready plus one request item).
// Depends on nothing.
interface hdcs_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic [5:0]         disk_index;
	logic signed [31:0] load_x;
	logic signed [31:0] load_y;
	logic signed [31:0] load_vx;
	logic signed [31:0] load_vy;

	modport source (output valid, req_type, disk_index, load_x, load_y, load_vx, load_vy,
		input ready);
	modport sink (input valid, req_type, disk_index, load_x, load_y, load_vx, load_vy,
		output ready);
endinterface

// ===== hdl/hdcs_resp_if.sv =====
// hdcs_resp_if: response channel (valid/ready plus one response item).
// Depends on nothing.
interface hdcs_resp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         resp_kind;
	logic signed [31:0] read_x;
	logic signed [31:0] read_y;
	logic signed [31:0] read_vx;
	logic signed [31:0] read_vy;

	modport source (output valid, resp_kind, read_x, read_y, read_vx, read_vy, input ready);
	modport sink (input valid, resp_kind, read_x, read_y, read_vx, read_vy, output ready);
endinterface

// ===== hdl/hard_disk_collision_step_core.sv =====
// hard_disk_collision_step_core: disk store with load, read and time-step requests.
// Depends on hdcs_pkg, hdcs_req_if and hdcs_resp_if.
//
// channel | dir | transfer when      | payload
// req     | in  | valid & ready      | req_type, disk_index, load_x/y, load_vx/vy
// resp    | out | valid & ready      | resp_kind, read_x/y, read_vx/vy
// wr_*    | in  | wr_en              | wr_index, wr_data (no read-back)
//
// A step first moves every active disk (read, multiply, write back), then takes
// each disk i in turn: it reads disk i, runs a pair pass over every later disk
// j > i and then applies the wall reflection. The one-read-port position/velocity
// memories allow one memory read per pair.
// arst_n clears control and config; the memories hold garbage until loaded.
// A finished response waits in the output register; a new request is taken
// while it is being drained in the same cycle.
module hard_disk_collision_step_core #(
	parameter int unsigned MAX_DISKS = hdcs_pkg::MAX_DISKS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [hdcs_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [hdcs_pkg::CFG_DAT_W-1:0]      wr_data,
	hdcs_req_if.sink                            req,
	hdcs_resp_if.source                         resp
);

	localparam int unsigned AW    = $clog2(MAX_DISKS);
	localparam int unsigned CNT_W = $clog2(MAX_DISKS + 1);

	// configuration
	logic [13:0] box_w_q, box_h_q;
	logic [23:0] radius_q, dt_q;
	logic [6:0]  act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_w_q  <= hdcs_pkg::BOX_W_RST;
			box_h_q  <= hdcs_pkg::BOX_H_RST;
			radius_q <= hdcs_pkg::RADIUS_RST;
			dt_q     <= hdcs_pkg::DT_RST;
			act_q    <= hdcs_pkg::ACTIVE_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				hdcs_pkg::CFG_BOX_W:  box_w_q  <= wr_data[13:0];
				hdcs_pkg::CFG_BOX_H:  box_h_q  <= wr_data[13:0];
				hdcs_pkg::CFG_RADIUS: radius_q <= wr_data;
				hdcs_pkg::CFG_DT:     dt_q     <= wr_data;
				hdcs_pkg::CFG_ACTIVE: act_q    <= wr_data[6:0];
				default: ;
			endcase
		end
	end

	// disk count clamped to the store depth
	logic [CNT_W-1:0] n_w;
	assign n_w = (32'(act_q) > 32'(MAX_DISKS)) ? CNT_W'(MAX_DISKS) : CNT_W'(act_q);

	// memories: {x, y} and {vx, vy}
	logic [63:0] pos_mem [MAX_DISKS];
	logic [63:0] vel_mem [MAX_DISKS];
	logic [63:0] pos_rd_q, vel_rd_q;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          pos_we, vel_we;
	logic [AW-1:0] pos_wa, vel_wa;
	logic [63:0]   pos_wd, vel_wd;

	always_ff @(posedge clk) begin
		if (pos_we)
			pos_mem[pos_wa] <= pos_wd;
		if (rd_en)
			pos_rd_q <= pos_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (vel_we)
			vel_mem[vel_wa] <= vel_wd;
		if (rd_en)
			vel_rd_q <= vel_mem[rd_addr];
	end

	function automatic logic [31:0] sat32(input logic [33:0] v);
		if (v[33:31] == 3'b000 || v[33:31] == 3'b111)
			return v[31:0];
		else if (v[33])
			return 32'h8000_0000;
		else
			return 32'h7FFF_FFFF;
	endfunction

	function automatic logic [31:0] neg_sat(input logic [31:0] v);
		if (v == 32'h8000_0000)
			return 32'h7FFF_FFFF;
		else
			return 32'(-v);
	endfunction

	hdcs_pkg::state_t state_q, state_d;
	hdcs_pkg::req_kind_t kind_q;
	logic             zero_q;
	logic [CNT_W-1:0] i_q, j_q;
	logic [CNT_W-1:0] i_nx;
	logic [31:0]      xi_q, yi_q, vxi_q, vyi_q;
	logic [49:0]      lim_q;

	// move products
	logic signed [56:0] mx_s1, my_s1;

	// pair pipeline: s1 = memory data, s2 = abs distances, s3 = squares
	logic          pv_s1, pv_s2, pv_s3;
	logic [AW-1:0] pj_s1, pj_s2, pj_s3;
	logic [24:0]   ax_s2, ay_s2;
	logic          close_s2, close_s3;
	logic [63:0]   vel_s2, vel_s3;
	logic [49:0]   sqx_s3, sqy_s3;

	// output register
	logic                out_v_q;
	hdcs_pkg::req_kind_t out_kind_q;
	logic [31:0]         out_x_q, out_y_q, out_vx_q, out_vy_q;

	logic out_free, req_acc, issue, contact, out_load, in_range;
	logic [32:0] dx, dy, ax, ay;
	logic [33:0] sum_x, sum_y;
	logic [32:0] xmax, ymax, r_ext;
	logic        wall_x, wall_y;

	assign out_free = !out_v_q || resp.ready;
	assign i_nx     = i_q + CNT_W'(1);
	assign in_range = 32'(req.disk_index) < 32'(MAX_DISKS);
	assign issue    = (state_q == hdcs_pkg::ST_PAIR) && (j_q < n_w);
	assign contact  = pv_s3 && close_s3 &&
		({1'b0, sqx_s3} + {1'b0, sqy_s3} <= {1'b0, lim_q});

	// pair distance terms
	assign dx = {xi_q[31], xi_q} - {pos_rd_q[63], pos_rd_q[63:32]};
	assign dy = {yi_q[31], yi_q} - {pos_rd_q[31], pos_rd_q[31:0]};
	assign ax = dx[32] ? 33'(-dx) : dx;
	assign ay = dy[32] ? 33'(-dy) : dy;

	// move sums: floor(v*dt / 2^24) is the arithmetic shift of the product
	assign sum_x = {{2{pos_rd_q[63]}}, pos_rd_q[63:32]} + {mx_s1[56], mx_s1[56:24]};
	assign sum_y = {{2{pos_rd_q[31]}}, pos_rd_q[31:0]} + {my_s1[56], my_s1[56:24]};

	// walls, strict compares at full precision
	assign r_ext  = {9'b0, radius_q};
	assign xmax   = {3'b0, box_w_q, 16'b0} - r_ext;
	assign ymax   = {3'b0, box_h_q, 16'b0} - r_ext;
	assign wall_x = ($signed({xi_q[31], xi_q}) < $signed(r_ext)) ||
		($signed({xi_q[31], xi_q}) > $signed(xmax));
	assign wall_y = ($signed({yi_q[31], yi_q}) < $signed(r_ext)) ||
		($signed({yi_q[31], yi_q}) > $signed(ymax));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hdcs_pkg::ST_IDLE: begin
				if (req.valid && out_free) begin
					if (req.req_type == hdcs_pkg::REQ_READ)
						state_d = hdcs_pkg::ST_RD_WAIT;
					else if (req.req_type == hdcs_pkg::REQ_STEP)
						state_d = (n_w == '0) ? hdcs_pkg::ST_RESP : hdcs_pkg::ST_MV_RD;
				end
			end
			hdcs_pkg::ST_RD_WAIT: state_d = hdcs_pkg::ST_RESP;
			hdcs_pkg::ST_MV_RD:   state_d = hdcs_pkg::ST_MV_MUL;
			hdcs_pkg::ST_MV_MUL:  state_d = hdcs_pkg::ST_MV_WR;
			hdcs_pkg::ST_MV_WR:
				state_d = (i_nx < n_w) ? hdcs_pkg::ST_MV_RD : hdcs_pkg::ST_PI_RD;
			hdcs_pkg::ST_PI_RD:   state_d = hdcs_pkg::ST_PI_LAT;
			hdcs_pkg::ST_PI_LAT:  state_d = hdcs_pkg::ST_PAIR;
			hdcs_pkg::ST_PAIR:
				if (!issue && !pv_s1 && !pv_s2 && !pv_s3)
					state_d = hdcs_pkg::ST_WALL;
			hdcs_pkg::ST_WALL:
				state_d = (i_nx < n_w) ? hdcs_pkg::ST_PI_RD : hdcs_pkg::ST_RESP;
			hdcs_pkg::ST_RESP:
				if (out_free)
					state_d = hdcs_pkg::ST_IDLE;
			default: state_d = hdcs_pkg::ST_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		req_acc  = 1'b0;
		out_load = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = i_q[AW-1:0];
		pos_we   = 1'b0;
		pos_wa   = i_q[AW-1:0];
		pos_wd   = {sat32(sum_x), sat32(sum_y)};
		vel_we   = 1'b0;
		vel_wa   = i_q[AW-1:0];
		vel_wd   = {wall_x ? neg_sat(vxi_q) : vxi_q, wall_y ? neg_sat(vyi_q) : vyi_q};
		unique case (state_q)
			hdcs_pkg::ST_IDLE: begin
				req_acc = out_free;
				if (req.valid && out_free) begin
					if (req.req_type == hdcs_pkg::REQ_READ) begin
						rd_en   = 1'b1;
						rd_addr = AW'(req.disk_index);
					end else if (req.req_type == hdcs_pkg::REQ_LOAD) begin
						out_load = 1'b1;
						pos_we   = in_range;
						pos_wa   = AW'(req.disk_index);
						pos_wd   = {req.load_x, req.load_y};
						vel_we   = in_range;
						vel_wa   = AW'(req.disk_index);
						vel_wd   = {req.load_vx, req.load_vy};
					end
				end
			end
			hdcs_pkg::ST_MV_RD, hdcs_pkg::ST_PI_RD: rd_en = 1'b1;
			hdcs_pkg::ST_MV_WR: pos_we = 1'b1;
			hdcs_pkg::ST_PAIR: begin
				rd_en   = issue;
				rd_addr = j_q[AW-1:0];
				vel_we  = contact;
				vel_wa  = pj_s3;
				vel_wd  = {vxi_q, vyi_q};
			end
			hdcs_pkg::ST_WALL: vel_we = 1'b1;
			hdcs_pkg::ST_RESP: out_load = out_free;
			default: ;
		endcase
	end

	assign req.ready = req_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= hdcs_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// counters and step working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q    <= '0;
			j_q    <= '0;
			kind_q <= hdcs_pkg::REQ_LOAD;
			zero_q <= 1'b0;
			pv_s1  <= 1'b0;
			pv_s2  <= 1'b0;
			pv_s3  <= 1'b0;
		end else begin
			pv_s1 <= issue;
			pv_s2 <= pv_s1;
			pv_s3 <= pv_s2;
			unique case (state_q)
				hdcs_pkg::ST_IDLE:
					if (req.valid && out_free) begin
						kind_q <= hdcs_pkg::req_kind_t'(req.req_type);
						zero_q <= !in_range;
						i_q    <= '0;
					end
				hdcs_pkg::ST_MV_WR: i_q <= (i_nx < n_w) ? i_nx : '0;
				hdcs_pkg::ST_PI_RD: j_q <= i_nx;
				hdcs_pkg::ST_PAIR:
					if (issue)
						j_q <= j_q + CNT_W'(1);
				hdcs_pkg::ST_WALL: i_q <= i_nx;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == hdcs_pkg::ST_IDLE)
			lim_q <= {48'({24'b0, radius_q} * {24'b0, radius_q}), 2'b00};
		mx_s1 <= $signed(vel_rd_q[63:32]) * $signed({1'b0, dt_q});
		my_s1 <= $signed(vel_rd_q[31:0]) * $signed({1'b0, dt_q});
		if (state_q == hdcs_pkg::ST_PI_LAT) begin
			xi_q  <= pos_rd_q[63:32];
			yi_q  <= pos_rd_q[31:0];
			vxi_q <= vel_rd_q[63:32];
			vyi_q <= vel_rd_q[31:0];
		end else if (state_q == hdcs_pkg::ST_PAIR && contact) begin
			vxi_q <= vel_s3[63:32];
			vyi_q <= vel_s3[31:0];
		end
		pj_s1    <= j_q[AW-1:0];
		pj_s2    <= pj_s1;
		ax_s2    <= ax[24:0];
		ay_s2    <= ay[24:0];
		close_s2 <= (ax <= {8'b0, radius_q, 1'b0}) && (ay <= {8'b0, radius_q, 1'b0});
		vel_s2   <= vel_rd_q;
		pj_s3    <= pj_s2;
		close_s3 <= close_s2;
		sqx_s3   <= ax_s2 * ax_s2;
		sqy_s3   <= ay_s2 * ay_s2;
		vel_s3   <= vel_s2;
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (out_load)
			out_v_q <= 1'b1;
		else if (resp.ready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == hdcs_pkg::ST_IDLE) begin
				out_kind_q <= hdcs_pkg::REQ_LOAD;
				out_x_q    <= '0;
				out_y_q    <= '0;
				out_vx_q   <= '0;
				out_vy_q   <= '0;
			end else begin
				out_kind_q <= kind_q;
				if (kind_q == hdcs_pkg::REQ_READ && !zero_q) begin
					out_x_q  <= pos_rd_q[63:32];
					out_y_q  <= pos_rd_q[31:0];
					out_vx_q <= vel_rd_q[63:32];
					out_vy_q <= vel_rd_q[31:0];
				end else begin
					out_x_q  <= '0;
					out_y_q  <= '0;
					out_vx_q <= '0;
					out_vy_q <= '0;
				end
			end
		end
	end

	assign resp.valid     = out_v_q;
	assign resp.resp_kind = out_kind_q;
	assign resp.read_x    = out_x_q;
	assign resp.read_y    = out_y_q;
	assign resp.read_vx   = out_vx_q;
	assign resp.read_vy   = out_vy_q;

endmodule

// ===== test/hard_disk_collision_step_core_tb.sv =====
// hard_disk_collision_step_core_tb: self-checking testbench for the disk collision step core.
// Depends on hdcs_pkg, hdcs_req_if, hdcs_resp_if and hard_disk_collision_step_core.
// A clocked driver feeds requests from a queue and a clocked monitor checks every response.
module hard_disk_collision_step_core_tb;

	localparam int NDISK     = 64;
	localparam int IDLE_LIM  = 40000;   // cycles without any transfer
	localparam int HOLD_LEN  = 3000;    // long receiver hold-off
	localparam int SETTLE    = 30;      // quiet cycles before a register write

	// one request as put on the request channel
	typedef struct {
		hdcs_pkg::req_kind_t kind;
		logic [5:0]          idx;
		logic signed [31:0]  x, y, vx, vy;
	} disk_req_t;

	// one response as expected on the response channel
	typedef struct {
		logic [1:0]         kind;
		logic signed [31:0] x, y, vx, vy;
	} disk_resp_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [hdcs_pkg::CFG_IDX_W-1:0] wr_index;
	logic [hdcs_pkg::CFG_DAT_W-1:0] wr_data;

	hdcs_req_if  req ();
	hdcs_resp_if resp ();

	hard_disk_collision_step_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.req      (req.sink),
		.resp     (resp.source)
	);

	always #5 clk = ~clk;

	// predictor copy of the disk store and the registers
	logic signed [31:0] pos_x [NDISK];
	logic signed [31:0] pos_y [NDISK];
	logic signed [31:0] vel_x [NDISK];
	logic signed [31:0] vel_y [NDISK];
	bit                 loaded [NDISK];
	logic [13:0] box_w, box_h;
	logic [23:0] radius, dt;
	logic [6:0]  n_active;

	disk_req_t  pending_reqs[$];
	disk_resp_t expected_resps[$];

	int unsigned sent_cnt, taken_cnt;
	int unsigned mismatches, checked;
	int unsigned n_loads, n_steps, n_reads, n_noops;
	int unsigned idle_cycles;
	bit          hold_armed;

	function automatic logic signed [31:0] sat32(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] negate_sat(input logic signed [31:0] v);
		return sat32(-longint'(v));
	endfunction

	// move every active disk, then pair pass and wall reflection per disk
	function automatic void advance_disks();
		int     n;
		longint r, two_r, lim, xmax, ymax, xi, yi, ax, ay;
		logic signed [31:0] tx, ty;
		n     = (n_active > NDISK) ? NDISK : n_active;
		r     = longint'(radius);
		two_r = 2 * r;
		lim   = 4 * r * r;
		xmax  = (longint'(box_w) <<< 16) - r;
		ymax  = (longint'(box_h) <<< 16) - r;
		for (int i = 0; i < n; i++) begin
			pos_x[i] = sat32(longint'(pos_x[i]) +
				((longint'(vel_x[i]) * longint'(dt)) >>> 24));
			pos_y[i] = sat32(longint'(pos_y[i]) +
				((longint'(vel_y[i]) * longint'(dt)) >>> 24));
		end
		for (int i = 0; i < n; i++) begin
			xi = pos_x[i];
			yi = pos_y[i];
			for (int j = i + 1; j < n; j++) begin
				ax = xi - longint'(pos_x[j]);
				ay = yi - longint'(pos_y[j]);
				if (ax < 0) ax = -ax;
				if (ay < 0) ay = -ay;
				// range test first keeps the squares inside 64 bits
				if (ax <= two_r && ay <= two_r && ax * ax + ay * ay <= lim) begin
					tx = vel_x[i];
					ty = vel_y[i];
					vel_x[i] = vel_x[j];
					vel_y[i] = vel_y[j];
					vel_x[j] = tx;
					vel_y[j] = ty;
				end
			end
			if (xi < r || xi > xmax) vel_x[i] = negate_sat(vel_x[i]);
			if (yi < r || yi > ymax) vel_y[i] = negate_sat(vel_y[i]);
		end
	endfunction

	// apply one accepted request to the predictor and queue its response
	function automatic void apply_request(input disk_req_t r);
		disk_resp_t e;
		e = '{kind: r.kind, x: 0, y: 0, vx: 0, vy: 0};
		case (r.kind)
			hdcs_pkg::REQ_LOAD: begin
				pos_x[r.idx] = r.x;
				pos_y[r.idx] = r.y;
				vel_x[r.idx] = r.vx;
				vel_y[r.idx] = r.vy;
				n_loads++;
			end
			hdcs_pkg::REQ_STEP: begin
				advance_disks();
				n_steps++;
			end
			hdcs_pkg::REQ_READ: begin
				e.x  = pos_x[r.idx];
				e.y  = pos_y[r.idx];
				e.vx = vel_x[r.idx];
				e.vy = vel_y[r.idx];
				n_reads++;
			end
			default: begin
				n_noops++;
				return;   // ignored, nothing comes back
			end
		endcase
		expected_resps.push_back(e);
	endfunction

	// ---------------------------------------------------------------
	// request driver: bursts of random length, random gaps between
	// ---------------------------------------------------------------
	int unsigned burst_left, gap_left;
	disk_req_t   cur;

	always @(negedge clk) begin
		if (arst_n) begin
			if (!req.valid || taken_cnt == sent_cnt) begin
				if (gap_left > 0) begin
					gap_left--;
					req.valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					cur = pending_reqs.pop_front();
					req.req_type   <= cur.kind;
					req.disk_index <= cur.idx;
					req.load_x     <= cur.x;
					req.load_y     <= cur.y;
					req.load_vx    <= cur.vx;
					req.load_vy    <= cur.vy;
					req.valid      <= 1'b1;
					sent_cnt++;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						// a zero gap about half the time keeps some stretches fully busy
						gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
					end else
						burst_left--;
				end else
					req.valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// response receiver: own stall pattern, plus one long hold-off
	// ---------------------------------------------------------------
	int unsigned hold_left, stall_pct, pattern_age;
	bit          hold_done;

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_armed && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN;
			end
			if (pattern_age == 0) begin
				pattern_age = $urandom_range(50, 400);
				case ($urandom_range(0, 3))
					0:       stall_pct = 0;
					1:       stall_pct = 25;
					2:       stall_pct = 60;
					default: stall_pct = 90;
				endcase
			end else
				pattern_age--;
			if (hold_left > 0) begin
				hold_left--;
				resp.ready <= 1'b0;
			end else
				resp.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// ---------------------------------------------------------------
	// monitor: predicts on request transfers, checks response transfers
	// ---------------------------------------------------------------
	disk_req_t  seen;
	disk_resp_t want;

	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready) begin
				seen.kind = hdcs_pkg::req_kind_t'(req.req_type);
				seen.idx  = req.disk_index;
				seen.x    = req.load_x;
				seen.y    = req.load_y;
				seen.vx   = req.load_vx;
				seen.vy   = req.load_vy;
				apply_request(seen);
				taken_cnt++;
			end
			if (resp.valid && resp.ready) begin
				checked++;
				if (expected_resps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected response: kind %0d x %h y %h vx %h vy %h",
							resp.resp_kind, resp.read_x, resp.read_y,
							resp.read_vx, resp.read_vy);
				end else begin
					want = expected_resps.pop_front();
					if (resp.resp_kind !== want.kind || resp.read_x !== want.x ||
						resp.read_y !== want.y || resp.read_vx !== want.vx ||
						resp.read_vy !== want.vy) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"response mismatch: exp kind %0d x %h y %h vx %h vy %h,",
								" got kind %0d x %h y %h vx %h vy %h"},
								want.kind, want.x, want.y, want.vx, want.vy,
								resp.resp_kind, resp.read_x, resp.read_y,
								resp.read_vx, resp.read_vy);
					end
				end
			end
			// watchdog on transfers of either channel
			if ((req.valid && req.ready) || (resp.valid && resp.ready))
				idle_cycles = 0;
			else if (++idle_cycles >= IDLE_LIM) begin
				$display("timeout: no transfer for %0d cycles", IDLE_LIM);
				$display("hard_disk_collision_step_core_tb failed");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------
	function automatic disk_req_t mk(input hdcs_pkg::req_kind_t k, input int idx,
		input logic [31:0] x, input logic [31:0] y, input logic [31:0] vx,
		input logic [31:0] vy);
		disk_req_t r;
		r.kind = k;
		r.idx  = idx[5:0];
		r.x    = x;
		r.y    = y;
		r.vx   = vx;
		r.vy   = vy;
		return r;
	endfunction

	// a sensible disk: inside a span of whole units, moderate velocity
	function automatic disk_req_t sane_disk(input int idx, input int span, input int vmax);
		logic [31:0] x, y, vx, vy;
		x  = ($urandom_range(0, span) << 16) + $urandom_range(0, 65535);
		y  = ($urandom_range(0, span) << 16) + $urandom_range(0, 65535);
		vx = $urandom_range(0, 2 * vmax) - vmax;
		vy = $urandom_range(0, 2 * vmax) - vmax;
		return mk(hdcs_pkg::REQ_LOAD, idx, x, y, vx, vy);
	endfunction

	// payload wires get random junk on steps and reads too
	function automatic disk_req_t junk(input hdcs_pkg::req_kind_t k, input int idx);
		return mk(k, idx, $urandom, $urandom, $urandom, $urandom);
	endfunction

	function automatic int pick_loaded();
		int i;
		do i = $urandom_range(0, NDISK - 1); while (!loaded[i]);
		return i;
	endfunction

	function automatic void queue_req(input disk_req_t r);
		if (r.kind == hdcs_pkg::REQ_LOAD)
			loaded[r.idx] = 1'b1;
		pending_reqs.push_back(r);
	endfunction

	// wait for the block to go quiet: nothing queued, nothing owed
	task automatic drain();
		while (pending_reqs.size() > 0 || taken_cnt != sent_cnt ||
			expected_resps.size() > 0 || req.valid)
			@(posedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_reg(input logic [hdcs_pkg::CFG_IDX_W-1:0] idx,
		input int unsigned val);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val[hdcs_pkg::CFG_DAT_W-1:0];
		case (idx)
			hdcs_pkg::CFG_BOX_W:  box_w    = val[13:0];
			hdcs_pkg::CFG_BOX_H:  box_h    = val[13:0];
			hdcs_pkg::CFG_RADIUS: radius   = val[23:0];
			hdcs_pkg::CFG_DT:     dt       = val[23:0];
			hdcs_pkg::CFG_ACTIVE: n_active = val[6:0];
			default: ;
		endcase
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic config_all(input int w, input int h, input int r, input int t,
		input int n);
		set_reg(hdcs_pkg::CFG_BOX_W, w);
		set_reg(hdcs_pkg::CFG_BOX_H, h);
		set_reg(hdcs_pkg::CFG_RADIUS, r);
		set_reg(hdcs_pkg::CFG_DT, t);
		set_reg(hdcs_pkg::CFG_ACTIVE, n);
	endtask

	// one random phase of well-formed traffic with some noise
	task automatic random_phase(input int items, input int span, input int vmax);
		int k;
		for (int it = 0; it < items; it++) begin
			k = $urandom_range(0, 99);
			if (k < 30)
				queue_req(sane_disk($urandom_range(0, NDISK - 1), span, vmax));
			else if (k < 36)
				queue_req(junk(hdcs_pkg::REQ_LOAD, $urandom_range(0, NDISK - 1)));
			else if (k < 56)
				queue_req(junk(hdcs_pkg::REQ_STEP, $urandom_range(0, NDISK - 1)));
			else if (k < 95)
				queue_req(junk(hdcs_pkg::REQ_READ, pick_loaded()));
			else
				queue_req(junk(hdcs_pkg::REQ_NONE, $urandom_range(0, NDISK - 1)));
		end
	endtask

	// ---------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		req.valid = 1'b0;
		req.req_type = hdcs_pkg::REQ_NONE;
		req.disk_index = '0;
		req.load_x = '0;
		req.load_y = '0;
		req.load_vx = '0;
		req.load_vy = '0;
		resp.ready = 1'b0;
		box_w = hdcs_pkg::BOX_W_RST;
		box_h = hdcs_pkg::BOX_H_RST;
		radius = hdcs_pkg::RADIUS_RST;
		dt = hdcs_pkg::DT_RST;
		n_active = hdcs_pkg::ACTIVE_RST;
		for (int i = 0; i < NDISK; i++) begin
			pos_x[i] = '0;
			pos_y[i] = '0;
			vel_x[i] = '0;
			vel_y[i] = '0;
			loaded[i] = 1'b0;
		end
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// reset settings: fill the whole store, clustered so that disks touch
		for (int i = 0; i < NDISK; i++)
			queue_req(sane_disk(i, 40, 4000 << 16));

		// directed: field extremes, every request kind, ignored kind,
		// saturating moves and negation of the most negative velocity
		queue_req(mk(hdcs_pkg::REQ_LOAD, 0, 32'h7fffffff, 32'h80000000,
			32'h80000000, 32'h7fffffff));
		queue_req(junk(hdcs_pkg::REQ_READ, 0));
		queue_req(mk(hdcs_pkg::REQ_LOAD, 63, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 32'h80000000));
		queue_req(junk(hdcs_pkg::REQ_READ, 63));
		queue_req(mk(hdcs_pkg::REQ_LOAD, 1, 32'hffff0000, 32'h0, 32'h80000000, 32'h0));
		queue_req(junk(hdcs_pkg::REQ_NONE, 5));
		queue_req(junk(hdcs_pkg::REQ_STEP, 0));
		queue_req(junk(hdcs_pkg::REQ_READ, 0));
		queue_req(junk(hdcs_pkg::REQ_READ, 1));
		queue_req(junk(hdcs_pkg::REQ_READ, 63));
		queue_req(junk(hdcs_pkg::REQ_NONE, 63));
		queue_req(junk(hdcs_pkg::REQ_STEP, 0));
		queue_req(junk(hdcs_pkg::REQ_READ, 1));
		drain();

		// degenerate box, largest radius and time step, a single disk
		config_all(1, 16383, 24'hffffff, 24'hffffff, 1);
		queue_req(mk(hdcs_pkg::REQ_LOAD, 0, 32'h00008000, 32'h00004000,
			32'h00010000, 32'hffff0000));
		queue_req(junk(hdcs_pkg::REQ_STEP, 0));
		queue_req(junk(hdcs_pkg::REQ_READ, 0));
		queue_req(junk(hdcs_pkg::REQ_STEP, 0));
		queue_req(junk(hdcs_pkg::REQ_READ, 0));
		drain();

		// no disks active, then count beyond the store, zero radius and zero dt
		config_all(16383, 1, 0, 0, 0);
		queue_req(junk(hdcs_pkg::REQ_STEP, 0));
		queue_req(junk(hdcs_pkg::REQ_READ, 0));
		drain();
		config_all(16383, 1, 0, 0, 127);
		queue_req(junk(hdcs_pkg::REQ_STEP, 0));
		queue_req(junk(hdcs_pkg::REQ_READ, 2));
		queue_req(junk(hdcs_pkg::REQ_READ, 62));
		drain();

		// random phases: mostly small disk counts, one full-size phase
		config_all(60, 60, 4 << 16, 1 << 22, 8);
		random_phase(35, 60, 20 << 16);
		drain();

		config_all(30, 40, 6 << 16, 1 << 23, 12);
		// long receiver hold-off while the sender keeps offering
		hold_armed = 1'b1;
		random_phase(35, 40, 10 << 16);
		drain();

		config_all(200, 150, 20 << 16, 24'hffffff, 64);
		random_phase(20, 200, 60 << 16);
		drain();

		config_all($urandom_range(1, 100), $urandom_range(1, 100),
			$urandom_range(1 << 16, 12 << 16), $urandom_range(0, 24'hffffff),
			$urandom_range(2, 16));
		random_phase(35, 100, 30 << 16);
		drain();

		config_all(16383, 16383, $urandom_range(0, 24'hffffff),
			$urandom_range(0, 24'hffffff), $urandom_range(2, 20));
		random_phase(30, 16383, 32'h7fffffff >> 1);
		drain();

		config_all(25, 25, 3 << 16, 1 << 23, 6);
		random_phase(35, 25, 8 << 16);
		drain();

		$display("covered %0d loads, %0d steps, %0d reads, %0d ignored requests; %0d checked",
			n_loads, n_steps, n_reads, n_noops, checked);
		$display("settings included degenerate box, zero and oversized disk counts, extreme radius and dt");
		if (mismatches == 0)
			$display("hard_disk_collision_step_core_tb passed");
		else
			$display("hard_disk_collision_step_core_tb failed");
		$finish;
	end
endmodule

// ===== sim.f =====
hdl/hdcs_pkg.sv
hdl/hdcs_req_if.sv
hdl/hdcs_resp_if.sv
hdl/hard_disk_collision_step_core.sv
test/hard_disk_collision_step_core_tb.sv
